@@ rtl/tccw_pkg.sv @@
// Package for the text console character writer.
// Holds operation codes, character codes, the blank cell value and default sizes.
// Has no dependencies; imported by text_console_char_writer, console_checker and the testbench.
package tccw_pkg;

   // Default screen geometry and tab spacing.
   localparam int DEF_COLUMNS   = 80;
   localparam int DEF_ROWS      = 25;
   localparam int DEF_TAB_WIDTH = 4;

   // Fixed widths of the beat fields.
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CELL_W-1:0] cell_type;

   // Operation codes.
   localparam func_type FUNC_PUT   = 2'd0;
   localparam func_type FUNC_CLEAR = 2'd1;
   localparam func_type FUNC_READ  = 2'd2;

   // Control and printable character codes.
   localparam char_type CH_BS         = 8'h08;
   localparam char_type CH_TAB        = 8'h09;
   localparam char_type CH_LF         = 8'h0A;
   localparam char_type CH_CR         = 8'h0D;
   localparam char_type CH_SPACE      = 8'h20;
   localparam char_type CH_LAST_PRINT = 8'h7F;

   // White-on-black space used by clear and by scrolling.
   localparam cell_type BLANK_CELL = 16'h0F20;

endpackage

@@ rtl/text_console_char_writer.sv @@
// Text console character writer: cursor logic, cell store and sweep sequencer.
// Depends on tccw_pkg for operation codes, character codes and default sizes.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | func, char_code, bg_color,
//           |           |                      | fg_color, cell_index
//   rsp     | out       | rsp_valid, rsp_stall | cursor_position, cell_data
//
// A put that does not scroll, and an unused operation code, leave the sequencer
// idle when the output register is free; a new beat can then be taken in the
// very next cycle. A cell read steps through accept, registered memory read and
// result. Clear and a put that scrolls sweep the cell store, one cell per cycle.
// Reset homes the cursor; the cell store is not cleared by reset.
// A result held by rsp_stall stays in the output register; the next beat is
// still taken, and its result waits in the sequencer until the register frees.
module text_console_char_writer #(
   parameter int COLUMNS   = tccw_pkg::DEF_COLUMNS,
   parameter int ROWS      = tccw_pkg::DEF_ROWS,
   parameter int TAB_WIDTH = tccw_pkg::DEF_TAB_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tccw_pkg::FUNC_W-1:0]   req_func,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::COLOR_W-1:0]  req_bg_color,
   input  logic [tccw_pkg::COLOR_W-1:0]  req_fg_color,
   input  logic [tccw_pkg::POS_W-1:0]    req_cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tccw_pkg::POS_W-1:0]    rsp_cursor_position,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_cell_data
);
   import tccw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int TPW   = $clog2(TAB_WIDTH);
   localparam int NCW   = $clog2(COLUMNS + TAB_WIDTH + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_SWEEP  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   function automatic logic [31:0] lin_pos(input logic [RW-1:0] r, input logic [CW-1:0] c);
      lin_pos = 32'(r) * 32'(COLUMNS) + 32'(c);
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [TPW-1:0]    phase_ff, phase_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              clear_ff, clear_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [CELL_W-1:0] data_ff, data_in;
   logic              stage_valid_ff, stage_valid_in;
   logic              stage_blank_ff, stage_blank_in;
   logic [AW-1:0]     stage_addr_ff, stage_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              rsp_free;
   logic [NCW-1:0]    put_col;
   logic [RW:0]       put_row;
   logic [TPW-1:0]    put_phase;
   logic              put_print;
   logic              put_scroll;
   logic              blank_now;
   logic [AW:0]       src_addr;

   // Cell store with one write and one registered read port.
   cell_type          mem [CELLS];
   cell_type          rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   cell_type          mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Cursor update for a put; the tab phase tracks column modulo the tab width.
   always_comb begin
      put_col   = NCW'(col_ff);
      put_row   = (RW+1)'(row_ff);
      put_phase = phase_ff;
      put_print = 1'b0;
      case (req_char_code) inside
         CH_BS: begin
            if (col_ff != '0) begin
               put_col   = put_col - NCW'(1);
               put_phase = (phase_ff == '0) ? TPW'(TAB_WIDTH - 1) : phase_ff - TPW'(1);
            end
         end
         CH_TAB: begin
            put_col   = put_col + NCW'(TAB_WIDTH) - NCW'(phase_ff);
            put_phase = '0;
         end
         CH_CR: begin
            put_col   = '0;
            put_phase = '0;
         end
         CH_LF: begin
            put_col   = '0;
            put_phase = '0;
            put_row   = put_row + (RW+1)'(1);
         end
         [CH_SPACE:CH_LAST_PRINT]: begin
            put_print = 1'b1;
            put_col   = put_col + NCW'(1);
            put_phase = (phase_ff == TPW'(TAB_WIDTH - 1)) ? '0 : phase_ff + TPW'(1);
         end
         default: begin
         end
      endcase
      // Wrap at the right edge.
      if (put_col >= NCW'(COLUMNS)) begin
         put_col   = '0;
         put_phase = '0;
         put_row   = put_row + (RW+1)'(1);
      end
      // Falling off the bottom scrolls and keeps the cursor on the last row.
      put_scroll = (put_row >= (RW+1)'(ROWS));
      if (put_scroll) begin
         put_row = (RW+1)'(ROWS - 1);
      end
   end

   // Sweep addressing: copy from one row below, or blank the cell.
   assign blank_now = clear_ff || (sweep_ff >= AW'(CELLS - COLUMNS));
   assign src_addr  = (AW+1)'(sweep_ff) + (AW+1)'(COLUMNS);

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      phase_in       = phase_ff;
      sweep_in       = sweep_ff;
      clear_in       = clear_ff;
      rd_ok_in       = rd_ok_ff;
      data_in        = data_ff;
      stage_valid_in = 1'b0;
      stage_blank_in = blank_now;
      stage_addr_in  = sweep_ff;
      rsp_valid_in   = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_pos_in     = rsp_pos_ff;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_waddr      = stage_addr_ff;
      mem_wdata      = stage_blank_ff ? BLANK_CELL : rd_data_ff;
      mem_re         = 1'b0;
      mem_raddr      = src_addr[AW-1:0];

      // The sweep pipeline writes in the cycle after its read was issued.
      if (stage_valid_ff) begin
         mem_we = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               data_in = '0;
               unique case (req_func)
                  FUNC_PUT: begin
                     col_in   = CW'(put_col);
                     row_in   = RW'(put_row);
                     phase_in = put_phase;
                     if (put_print) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(lin_pos(row_ff, col_ff));
                        mem_wdata = {req_bg_color, req_fg_color, req_char_code};
                     end
                     if (put_scroll) begin
                        clear_in = 1'b0;
                        sweep_in = '0;
                        state_in = S_SWEEP;
                     end else if (rsp_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = POS_W'(lin_pos(RW'(put_row), CW'(put_col)));
                        rsp_data_in  = '0;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  FUNC_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                     clear_in = 1'b1;
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  FUNC_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(req_cell_index);
                     rd_ok_in  = (32'(req_cell_index) < 32'(CELLS));
                     state_in  = S_READ;
                  end
                  default: begin
                     if (rsp_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = POS_W'(lin_pos(row_ff, col_ff));
                        rsp_data_in  = '0;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            data_in  = rd_ok_ff ? rd_data_ff : '0;
            state_in = S_FINISH;
         end
         S_SWEEP: begin
            stage_valid_in = 1'b1;
            if (!blank_now) begin
               mem_re = 1'b1;
            end
            if (sweep_ff == AW'(CELLS - 1)) begin
               state_in = S_FINISH;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(lin_pos(row_ff, col_ff));
               rsp_data_in  = data_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         col_ff         <= '0;
         row_ff         <= '0;
         phase_ff       <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         phase_ff       <= phase_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sweep_ff       <= sweep_in;
      clear_ff       <= clear_in;
      rd_ok_ff       <= rd_ok_in;
      data_ff        <= data_in;
      stage_blank_ff <= stage_blank_in;
      stage_addr_ff  <= stage_addr_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Cell store write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_data       = rsp_data_ff;

   // The cursor always stays on the screen and the tab phase in range.
   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS))
      && (32'(phase_ff) < 32'(TAB_WIDTH)))
      else $error("cursor out of range");

   // A sweep write never collides with a character write on the single port.
   a_write_port: assert property (@(posedge clock) disable iff (reset)
      !(stage_valid_ff && state_ff == S_IDLE && req_accept && req_func == FUNC_PUT
        && put_print))
      else $error("write port conflict");

   // Sweep writes only follow a sweep cycle.
   a_stage_origin: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |-> $past(state_ff) == S_SWEEP)
      else $error("sweep write without sweep");

endmodule

@@ test/console_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the text console character writer: keeps its own cursor and
// cell store, works out the result of every accepted request beat and compares it.
// Depends on tccw_pkg for operation codes, character codes and field widths.
module console_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [tccw_pkg::FUNC_W-1:0]  req_func,
   input  logic [tccw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tccw_pkg::COLOR_W-1:0] req_bg_color,
   input  logic [tccw_pkg::COLOR_W-1:0] req_fg_color,
   input  logic [tccw_pkg::POS_W-1:0]   req_cell_index,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [tccw_pkg::POS_W-1:0]   rsp_cursor_position,
   input  logic [tccw_pkg::CELL_W-1:0]  rsp_cell_data,
   output int                           failures,
   output int                           pending_beats
);
   import tccw_pkg::*;

   localparam int COLS  = DEF_COLUMNS;
   localparam int LINES = DEF_ROWS;
   localparam int TAB   = DEF_TAB_WIDTH;
   localparam int CELLS = COLS * LINES;

   typedef struct packed {
      logic [POS_W-1:0] cursor;
      cell_type         data_word;
   } console_result_type;

   // Mirror of the console state.
   logic [6:0]         col = '0;
   logic [4:0]         row = '0;
   cell_type           screen [CELLS];
   console_result_type awaited_results [$];
   int                 tally = 0;

   initial begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
   end

   // Move every row up by one and blank the bottom row.
   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = BLANK_CELL;
   endfunction

   // Apply one character to the cursor and the cell store.
   function automatic void place_char(input char_type code,
                                      input logic [COLOR_W-1:0] back,
                                      input logic [COLOR_W-1:0] fore);
      int addr;
      addr = row * COLS + col;
      case (code)
         CH_BS: begin
            if (col != 0) col = col - 1'b1;
         end
         CH_TAB: col = 7'(col + TAB - (col % TAB));
         CH_CR:  col = '0;
         CH_LF: begin
            col = '0;
            row = row + 1'b1;
         end
         default: begin
            // Printable codes land in the cell under the cursor; the rest are dropped.
            if (code >= CH_SPACE && code <= CH_LAST_PRINT) begin
               screen[addr] = {back, fore, code};
               col = col + 1'b1;
            end
         end
      endcase
      if (col >= COLS) begin
         col = '0;
         row = row + 1'b1;
      end
      if (row >= LINES) begin
         scroll_screen();
         row = 5'(LINES - 1);
      end
   endfunction

   // Work out the result beat that one request beat causes.
   function automatic console_result_type predict_console_beat(
         input func_type op, input char_type code,
         input logic [COLOR_W-1:0] back, input logic [COLOR_W-1:0] fore,
         input logic [POS_W-1:0] index);
      console_result_type res;
      res.data_word = '0;
      case (op)
         FUNC_PUT: place_char(code, back, fore);
         FUNC_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
            col = '0;
            row = '0;
         end
         FUNC_READ: begin
            if (index < CELLS) res.data_word = screen[index];
         end
         default: ;
      endcase
      res.cursor = POS_W'(row * COLS + col);
      return res;
   endfunction

   // Results are matched before new requests are queued, so a beat cannot meet
   // the expectation of the request taken at the same edge.
   always @(posedge clock) begin : watch
      console_result_type want;
      if (reset) begin
         col = '0;
         row = '0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result beat, cursor_position %0d, cell_data %h",
                        $time, rsp_cursor_position, rsp_cell_data);
               tally++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_cursor_position !== want.cursor) begin
                  $display("%0t: cursor_position expected %0d, got %0d",
                           $time, want.cursor, rsp_cursor_position);
                  tally++;
               end
               if (rsp_cell_data !== want.data_word) begin
                  $display("%0t: cell_data expected %h, got %h",
                           $time, want.data_word, rsp_cell_data);
                  tally++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            awaited_results.push_back(predict_console_beat(req_func, req_char_code,
               req_bg_color, req_fg_color, req_cell_index));
         end
      end
      pending_beats <= awaited_results.size();
      failures      <= tally;
   end

endmodule

@@ test/text_console_char_writer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the text console character writer: clock, reset, request beats
// with random gaps and random stall on the result channel; the verdict comes last.
// Depends on tccw_pkg, text_console_char_writer and console_checker.
module text_console_char_writer_tb;
   import tccw_pkg::*;

   localparam func_type         FUNC_UNUSED   = 2'd3;
   localparam char_type         CH_NUL        = 8'h00;
   localparam char_type         CH_LAST_CTRL  = 8'h1F;
   localparam char_type         CH_HIGH_FIRST = 8'h80;
   localparam char_type         CH_HIGH_LAST  = 8'hFF;
   localparam char_type         CH_LETTER_A   = 8'h41;
   localparam logic [COLOR_W-1:0] COLOR_MIN   = '0;
   localparam logic [COLOR_W-1:0] COLOR_MAX   = '1;
   localparam logic [POS_W-1:0] FIRST_CELL    = 11'd0;
   localparam logic [POS_W-1:0] LAST_CELL     = 11'd1999;
   localparam logic [POS_W-1:0] FIRST_OUTSIDE = 11'd2000;
   localparam logic [POS_W-1:0] TOP_INDEX     = 11'h7FF;
   localparam int LONG_HOLD     = 60;
   localparam int BEAT_TARGET   = 560;
   localparam int PHASE_BEATS   = 60;
   localparam int SETTLE_CYCLES = 2100;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic [FUNC_W-1:0]   req_func       = '0;
   logic [CHAR_W-1:0]   req_char_code  = '0;
   logic [COLOR_W-1:0]  req_bg_color   = '0;
   logic [COLOR_W-1:0]  req_fg_color   = '0;
   logic [POS_W-1:0]    req_cell_index = '0;
   logic                rsp_stall      = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [POS_W-1:0]    rsp_cursor_position;
   logic [CELL_W-1:0]   rsp_cell_data;
   int                  failures;
   int                  pending_beats;

   bit quiet        = 1'b0;
   bit long_hold    = 1'b0;
   int useful_beats = 0;

   always #10 clock = ~clock;

   text_console_char_writer dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_char_code,
      .req_bg_color, .req_fg_color, .req_cell_index,
      .rsp_valid, .rsp_stall, .rsp_cursor_position, .rsp_cell_data
   );

   console_checker u_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_char_code,
      .req_bg_color, .req_fg_color, .req_cell_index,
      .rsp_valid, .rsp_stall, .rsp_cursor_position, .rsp_cell_data,
      .failures, .pending_beats
   );

   // Offer one request beat after a random gap and wait until it is taken.
   task automatic offer_beat(input func_type op, input char_type code,
                             input logic [COLOR_W-1:0] back,
                             input logic [COLOR_W-1:0] fore,
                             input logic [POS_W-1:0] index);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= op;
      req_char_code  <= code;
      req_bg_color   <= back;
      req_fg_color   <= fore;
      req_cell_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op != FUNC_UNUSED) useful_beats++;
   endtask

   task automatic offer_char(input char_type code, input logic [COLOR_W-1:0] back,
                             input logic [COLOR_W-1:0] fore);
      offer_beat(FUNC_PUT, code, back, fore, 11'($urandom_range(0, 2047)));
   endtask

   task automatic offer_read(input logic [POS_W-1:0] index);
      offer_beat(FUNC_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), index);
   endtask

   // Stop offering and wait until every awaited result beat has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   // One random beat; the weights of line feeds and clears shape the phase.
   task automatic offer_random_beat(input int lf_w, input int clear_w);
      int unsigned pick;
      func_type    op;
      char_type    code;
      pick = $urandom_range(0, 99);
      op   = FUNC_PUT;
      code = 8'($urandom_range(CH_SPACE, CH_LAST_PRINT));
      if (pick < clear_w) op = FUNC_CLEAR;
      else if (pick < clear_w + lf_w) code = CH_LF;
      else if (pick < clear_w + lf_w + 4) code = CH_CR;
      else if (pick < clear_w + lf_w + 8) code = CH_TAB;
      else if (pick < clear_w + lf_w + 12) code = CH_BS;
      else if (pick < clear_w + lf_w + 16) code = 8'($urandom_range(0, 255));
      else if (pick < clear_w + lf_w + 30) op = FUNC_READ;
      else if (pick < clear_w + lf_w + 33) op = FUNC_UNUSED;
      if (op != FUNC_PUT && op != FUNC_UNUSED) code = 8'($urandom_range(0, 255));
      offer_beat(op, code, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 11'($urandom_range(0, 2047)));
   endtask

   // The result side stalls for a random count before each beat, or for a long
   // stretch when asked, or not at all in quiet phases.
   initial begin : result_side
      int unsigned hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            hold      = LONG_HOLD;
            long_hold = 1'b0;
         end else if (quiet) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 4);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : request_side
      int phase;
      int lf_w;
      int clear_w;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: the clear comes first so that no cell is read unwritten.
      offer_beat(FUNC_CLEAR, CH_HIGH_LAST, COLOR_MAX, COLOR_MAX, TOP_INDEX);
      offer_read(FIRST_CELL);
      offer_char(CH_LETTER_A, COLOR_MIN, COLOR_MAX);
      offer_char(CH_LAST_PRINT, COLOR_MAX, COLOR_MIN);
      offer_char(CH_SPACE, COLOR_MAX, COLOR_MAX);
      offer_read(11'd0);
      offer_read(11'd1);
      offer_read(11'd2);
      offer_char(CH_BS, COLOR_MIN, COLOR_MIN);
      offer_char(CH_CR, COLOR_MAX, COLOR_MAX);
      // Backspace while already in the first column does nothing.
      offer_char(CH_BS, COLOR_MAX, COLOR_MIN);
      offer_char(CH_TAB, COLOR_MIN, COLOR_MAX);
      offer_char(CH_TAB, COLOR_MAX, COLOR_MIN);
      offer_char(CH_LF, COLOR_MIN, COLOR_MIN);
      // Other control codes and the upper half of the code range are ignored.
      offer_char(CH_NUL, COLOR_MAX, COLOR_MAX);
      offer_char(CH_LAST_CTRL, COLOR_MAX, COLOR_MAX);
      offer_char(CH_HIGH_FIRST, COLOR_MAX, COLOR_MAX);
      offer_char(CH_HIGH_LAST, COLOR_MAX, COLOR_MAX);
      offer_beat(FUNC_UNUSED, CH_HIGH_LAST, COLOR_MAX, COLOR_MAX, TOP_INDEX);
      offer_read(LAST_CELL);
      offer_read(FIRST_OUTSIDE);
      offer_read(TOP_INDEX);
      drain();

      // Hold the result side off while beats keep coming, so the block backs up.
      long_hold = 1'b1;
      quiet     = 1'b1;
      repeat (12) begin
         offer_char(8'($urandom_range(CH_SPACE, CH_LAST_PRINT)),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
      quiet = 1'b0;
      drain();

      // Random phases: long lines to wrap, many lines to scroll, and a mix with clears.
      phase = 0;
      while (useful_beats < BEAT_TARGET) begin
         quiet = (phase % 4 == 3);
         case (phase % 3)
            0: begin
               lf_w    = 1;
               clear_w = 0;
            end
            1: begin
               lf_w    = 15;
               clear_w = 0;
            end
            default: begin
               lf_w    = 6;
               clear_w = 2;
            end
         endcase
         repeat (PHASE_BEATS) offer_random_beat(lf_w, clear_w);
         if (phase % 2 == 1) drain();
         phase++;
      end
      quiet = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : run_limit
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
